// ===== rtl/clcd_pkg.sv =====
package clcd_pkg;

    // Store depths and the address map of the two-line layout.
    localparam int DisplayDepth = 80;
    localparam int CharDepth    = 64;
    localparam int LineOneEnd   = 40;
    localparam int LineTwoStart = 64;
    localparam int LineGap      = 24;
    localparam int VirtSpan     = 104;
    localparam int ShiftMin     = -80;
    localparam int ShiftMax     = 79;
    localparam int ShiftSpan    = 160;
    localparam logic [7:0] BlankChar = 8'h20;

    localparam int DdAddrW = $clog2(DisplayDepth);
    localparam int CgAddrW = $clog2(CharDepth);

    // Bit positions of the instruction opcodes, highest priority first.
    localparam int IrSetDdram   = 7;
    localparam int IrSetCgram   = 6;
    localparam int IrFunction   = 5;
    localparam int IrShift      = 4;
    localparam int IrDisplayCtl = 3;
    localparam int IrEntryMode  = 2;
    localparam int IrHome       = 1;
    localparam int IrClear      = 0;

    // Bit positions of the interface mode register.
    localparam int ModeEight = 0;
    localparam int ModeTwo   = 1;
    localparam int ModeTall  = 2;

    // One access to the character stores, issued for a single cycle.
    typedef struct packed {
        logic               we;
        logic               re;
        logic               cg;
        logic               clear;
        logic [DdAddrW-1:0] waddr;
        logic [DdAddrW-1:0] raddr;
        logic [7:0]         wdata;
    } t_mem_req;

    // Fold a requested display address into the valid range of the layout.
    function automatic logic [6:0] virt_valid(input logic [6:0] a, input logic two);
        logic [6:0] r;
        if (!two) begin
            r = (a >= 7'(DisplayDepth)) ? a - 7'(DisplayDepth) : a;
        end else begin
            r = (a >= 7'(VirtSpan)) ? a - 7'(VirtSpan) : a;
            if (r >= 7'(LineOneEnd) && r < 7'(LineTwoStart)) begin
                r = 7'(LineTwoStart);
            end
        end
        return r;
    endfunction

    // Map an address counter value onto a display store entry.
    function automatic logic [6:0] virt_to_phys(input logic [6:0] a, input logic two);
        logic [6:0] p;
        p = a;
        if (two) begin
            if (a >= 7'(LineTwoStart)) begin
                p = a - 7'(LineGap);
            end else if (a >= 7'(LineOneEnd)) begin
                p = 7'(LineOneEnd);
            end
        end
        if (p >= 7'(DisplayDepth)) begin
            p = p - 7'(DisplayDepth);
        end
        return p;
    endfunction

    // Map a display store entry back onto the address counter.
    function automatic logic [6:0] phys_to_virt(input logic [6:0] p, input logic two);
        return (two && p >= 7'(LineOneEnd)) ? p + 7'(LineGap) : p;
    endfunction

    // Move a display store entry by one place, wrapping round the store.
    function automatic logic [6:0] step_phys(input logic [6:0] p, input logic up);
        logic [6:0] r;
        if (up) begin
            r = (p == 7'(DisplayDepth - 1)) ? 7'd0 : p + 7'd1;
        end else begin
            r = (p == 7'd0) ? 7'(DisplayDepth - 1) : p - 7'd1;
        end
        return r;
    endfunction

endpackage

// ===== rtl/char_lcd_controller_bus.sv =====
// Channel   Handshake                  Payload
// request   i_in_valid / o_in_ready    i_op, i_rs, i_bus
// result    o_out_valid / i_out_ready  o_read_data, o_read_valid, o_address_counter,
//                                      o_cgram_selected, o_display_on, o_cursor_on,
//                                      o_blink_on, o_display_shift, o_two_lines, o_tall_font
//
// A request passes through accept, execute, prefetch load and result push; requests
// that read no store entry skip the load, and the push waits while the output is stalled.
// Reset is synchronous and active low; clear display and reset take effect at once
// through per-entry valid bits, so no clearing pass is needed.
// A finished result waits in the output register while the next request is taken.
module char_lcd_controller_bus (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_op,
    input  logic              i_rs,
    input  logic [7:0]        i_bus,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_read_data,
    output logic              o_read_valid,
    output logic [6:0]        o_address_counter,
    output logic              o_cgram_selected,
    output logic              o_display_on,
    output logic              o_cursor_on,
    output logic              o_blink_on,
    output logic signed [7:0] o_display_shift,
    output logic              o_two_lines,
    output logic              o_tall_font
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD,
        ST_PUSH
    } t_state;

    t_state r_state;

    // Captured request.
    logic       r_op;
    logic       r_rs;
    logic [7:0] r_bus;

    // Architectural state.
    logic [6:0]        r_ac,    n_ac;
    logic [6:0]        r_pa,    n_pa;
    logic [7:0]        r_dr;
    logic              r_sel,   n_sel;
    logic              r_dec,   n_dec;
    logic              r_shen,  n_shen;
    logic signed [7:0] r_shift, n_shift;
    logic [2:0]        r_flags, n_flags;
    logic [2:0]        r_mode,  n_mode;
    logic              r_phase, n_phase;
    logic [7:0]        r_hold,  n_hold;
    logic [7:0]        r_rd,    n_rd;

    // Output register.
    logic              r_o_valid;
    logic [7:0]        r_o_read_data;
    logic              r_o_read_valid;
    logic [6:0]        r_o_ac;
    logic              r_o_sel;
    logic [2:0]        r_o_flags;
    logic signed [7:0] r_o_shift;
    logic              r_o_two;
    logic              r_o_tall;

    clcd_pkg::t_mem_req w_req;
    clcd_pkg::t_mem_req w_mem;
    logic [7:0]         w_rdata;

    logic              w_two;
    logic              w_done;
    logic              w_step;
    logic [7:0]        w_val;
    logic [7:0]        w_byte;
    logic [6:0]        w_pa_step;
    logic [5:0]        w_cg_step;
    logic signed [8:0] w_sum;
    logic signed [8:0] w_wrap;

    assign w_two     = r_mode[clcd_pkg::ModeTwo];
    assign w_pa_step = clcd_pkg::step_phys(r_pa, !r_dec);
    assign w_cg_step = r_dec ? r_ac[5:0] - 6'd1 : r_ac[5:0] + 6'd1;

    // Display shift by one place, wrapped into the signed window.
    assign w_sum  = $signed({r_shift[7], r_shift}) + (w_byte[2] ? -9'sd1 : 9'sd1);
    assign w_wrap = (w_sum < 9'(clcd_pkg::ShiftMin)) ? w_sum + 9'(clcd_pkg::ShiftSpan) :
                    (w_sum > 9'(clcd_pkg::ShiftMax)) ? w_sum - 9'(clcd_pkg::ShiftSpan) :
                    w_sum;

    // Execute one bus cycle: nibble assembly, instruction decode and store access.
    always_comb begin
        n_ac    = r_ac;
        n_pa    = r_pa;
        n_sel   = r_sel;
        n_dec   = r_dec;
        n_shen  = r_shen;
        n_shift = r_shift;
        n_flags = r_flags;
        n_mode  = r_mode;
        n_phase = r_phase;
        n_hold  = r_hold;
        n_rd    = 8'h00;
        w_done  = 1'b0;
        w_step  = 1'b0;
        w_val   = 8'h00;
        w_byte  = 8'h00;
        w_req   = '0;

        if (r_op) begin
            w_val = r_rs ? r_dr : {1'b0, r_ac};
            if (r_mode[clcd_pkg::ModeEight]) begin
                n_rd   = w_val;
                w_done = 1'b1;
            end else if (!r_phase) begin
                n_rd    = {w_val[7:4], 4'h0};
                n_phase = 1'b1;
            end else begin
                n_rd    = {w_val[3:0], 4'h0};
                n_phase = 1'b0;
                w_done  = 1'b1;
            end
            w_step = w_done && r_rs;
        end else begin
            if (r_mode[clcd_pkg::ModeEight]) begin
                w_byte = r_bus;
                w_done = 1'b1;
            end else if (!r_phase) begin
                n_hold  = {r_bus[7:4], 4'h0};
                n_phase = 1'b1;
            end else begin
                w_byte  = r_hold | {4'h0, r_bus[7:4]};
                n_hold  = w_byte;
                n_phase = 1'b0;
                w_done  = 1'b1;
            end

            if (w_done && r_rs) begin
                // Data write at the address counter, then step and prefetch.
                w_req.we    = 1'b1;
                w_req.cg    = r_sel;
                w_req.wdata = w_byte;
                w_req.waddr = r_sel ? {1'b0, r_ac[5:0]} : clcd_pkg::virt_to_phys(r_ac, w_two);
                w_step      = 1'b1;
            end else if (w_done) begin
                if (w_byte[clcd_pkg::IrSetDdram]) begin
                    n_ac        = clcd_pkg::virt_valid(w_byte[6:0], w_two);
                    n_pa        = clcd_pkg::virt_to_phys(n_ac, w_two);
                    n_sel       = 1'b0;
                    w_req.re    = 1'b1;
                    w_req.raddr = n_pa;
                end else if (w_byte[clcd_pkg::IrSetCgram]) begin
                    n_ac        = {1'b0, w_byte[5:0]};
                    n_sel       = 1'b1;
                    w_req.re    = 1'b1;
                    w_req.cg    = 1'b1;
                    w_req.raddr = {1'b0, w_byte[5:0]};
                end else if (w_byte[clcd_pkg::IrFunction]) begin
                    n_mode  = {w_byte[2], w_byte[3], w_byte[4]};
                    n_phase = 1'b0;
                end else if (w_byte[clcd_pkg::IrShift]) begin
                    if (w_byte[3]) begin
                        if (r_shen) begin
                            n_shift = w_wrap[7:0];
                        end
                    end else if (!r_sel) begin
                        n_pa = clcd_pkg::step_phys(r_pa, w_byte[2]);
                        n_ac = clcd_pkg::phys_to_virt(n_pa, w_two);
                    end
                end else if (w_byte[clcd_pkg::IrDisplayCtl]) begin
                    n_flags = w_byte[2:0];
                end else if (w_byte[clcd_pkg::IrEntryMode]) begin
                    n_dec  = !w_byte[1];
                    n_shen = w_byte[0];
                end else if (w_byte[clcd_pkg::IrHome]) begin
                    n_ac     = 7'd0;
                    n_pa     = 7'd0;
                    n_sel    = 1'b0;
                    n_shift  = 8'sd0;
                    w_req.re = 1'b1;
                end else if (w_byte[clcd_pkg::IrClear]) begin
                    n_ac        = 7'd0;
                    n_pa        = 7'd0;
                    n_sel       = 1'b0;
                    n_shift     = 8'sd0;
                    n_dec       = 1'b0;
                    w_req.clear = 1'b1;
                    w_req.re    = 1'b1;
                end
            end
        end

        // Address step with prefetch of the new entry.
        if (w_step) begin
            w_req.re = 1'b1;
            if (!r_sel) begin
                n_pa        = w_pa_step;
                n_ac        = clcd_pkg::phys_to_virt(w_pa_step, w_two);
                w_req.cg    = 1'b0;
                w_req.raddr = w_pa_step;
            end else begin
                n_ac        = {1'b0, w_cg_step};
                w_req.cg    = 1'b1;
                w_req.raddr = {1'b0, w_cg_step};
            end
        end
    end

    // The store sees an access only in the execute cycle.
    assign w_mem = (r_state == ST_EXEC) ? w_req : '0;

    clcd_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mem),
        .o_rdata (w_rdata)
    );

    // Sequencer, architectural state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_op           <= 1'b0;
            r_rs           <= 1'b0;
            r_bus          <= 8'h00;
            r_ac           <= 7'd0;
            r_pa           <= 7'd0;
            r_dr           <= clcd_pkg::BlankChar;
            r_sel          <= 1'b0;
            r_dec          <= 1'b0;
            r_shen         <= 1'b0;
            r_shift        <= 8'sd0;
            r_flags        <= 3'd0;
            r_mode         <= 3'b001;
            r_phase        <= 1'b0;
            r_hold         <= 8'h00;
            r_rd           <= 8'h00;
            r_o_valid      <= 1'b0;
            r_o_read_data  <= 8'h00;
            r_o_read_valid <= 1'b0;
            r_o_ac         <= 7'd0;
            r_o_sel        <= 1'b0;
            r_o_flags      <= 3'd0;
            r_o_shift      <= 8'sd0;
            r_o_two        <= 1'b0;
            r_o_tall       <= 1'b0;
        end else begin
            // The push state refills the output register itself.
            if (r_o_valid && i_out_ready && r_state != ST_PUSH) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_op;
                        r_rs    <= i_rs;
                        r_bus   <= i_bus;
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_ac    <= n_ac;
                    r_pa    <= n_pa;
                    r_sel   <= n_sel;
                    r_dec   <= n_dec;
                    r_shen  <= n_shen;
                    r_shift <= n_shift;
                    r_flags <= n_flags;
                    r_mode  <= n_mode;
                    r_phase <= n_phase;
                    r_hold  <= n_hold;
                    r_rd    <= n_rd;
                    r_state <= w_req.re ? ST_LOAD : ST_PUSH;
                end
                ST_LOAD: begin
                    r_dr    <= w_rdata;
                    r_state <= ST_PUSH;
                end
                ST_PUSH: begin
                    if (!r_o_valid || i_out_ready) begin
                        r_o_valid      <= 1'b1;
                        r_o_read_data  <= r_rd;
                        r_o_read_valid <= r_op;
                        r_o_ac         <= r_ac;
                        r_o_sel        <= r_sel;
                        r_o_flags      <= r_flags;
                        r_o_shift      <= r_shift;
                        r_o_two        <= r_mode[clcd_pkg::ModeTwo];
                        r_o_tall       <= r_mode[clcd_pkg::ModeTall];
                        r_state        <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready        = (r_state == ST_IDLE);
    assign o_out_valid       = r_o_valid;
    assign o_read_data       = r_o_read_data;
    assign o_read_valid      = r_o_read_valid;
    assign o_address_counter = r_o_ac;
    assign o_cgram_selected  = r_o_sel;
    assign o_display_on      = r_o_flags[2];
    assign o_cursor_on       = r_o_flags[1];
    assign o_blink_on        = r_o_flags[0];
    assign o_display_shift   = r_o_shift;
    assign o_two_lines       = r_o_two;
    assign o_tall_font       = r_o_tall;

endmodule

// ===== rtl/clcd_store.sv =====
module clcd_store (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  clcd_pkg::t_mem_req i_req,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_dd [clcd_pkg::DisplayDepth];
    logic [7:0] r_cg [clcd_pkg::CharDepth];
    logic [clcd_pkg::DisplayDepth-1:0] r_dd_vld;
    logic [clcd_pkg::CharDepth-1:0]    r_cg_vld;
    logic [7:0] r_rdata;
    logic       r_rvld;
    logic       r_rcg;
    logic       w_fwd;

    // A read of the entry written in the same cycle returns the new byte.
    assign w_fwd = i_req.we && i_req.re && (i_req.waddr == i_req.raddr);

    // Valid bits: an entry never written since reset (or, in the display store, since clear) reads as its reset value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dd_vld <= '0;
            r_cg_vld <= '0;
            r_rvld   <= 1'b0;
        end else begin
            if (i_req.clear) begin
                r_dd_vld <= '0;
            end else if (i_req.we && !i_req.cg) begin
                r_dd_vld[i_req.waddr] <= 1'b1;
            end
            if (i_req.we && i_req.cg) begin
                r_cg_vld[i_req.waddr[clcd_pkg::CgAddrW-1:0]] <= 1'b1;
            end
            if (i_req.re) begin
                if (w_fwd) begin
                    r_rvld <= 1'b1;
                end else if (i_req.cg) begin
                    r_rvld <= r_cg_vld[i_req.raddr[clcd_pkg::CgAddrW-1:0]];
                end else begin
                    r_rvld <= r_dd_vld[i_req.raddr] && !i_req.clear;
                end
            end
        end
    end

    // Storage arrays with a registered read port.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            if (i_req.cg) begin
                r_cg[i_req.waddr[clcd_pkg::CgAddrW-1:0]] <= i_req.wdata;
            end else begin
                r_dd[i_req.waddr] <= i_req.wdata;
            end
        end
        if (i_req.re) begin
            r_rcg <= i_req.cg;
            if (w_fwd) begin
                r_rdata <= i_req.wdata;
            end else if (i_req.cg) begin
                r_rdata <= r_cg[i_req.raddr[clcd_pkg::CgAddrW-1:0]];
            end else begin
                r_rdata <= r_dd[i_req.raddr];
            end
        end
    end

    // Substitute the reset contents for entries that hold nothing yet.
    assign o_rdata = r_rvld ? r_rdata : (r_rcg ? 8'h00 : clcd_pkg::BlankChar);

endmodule

// ===== rtl/clcd_checker.sv =====
module clcd_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [7:0]        o_read_data,
    input logic              o_read_valid,
    input logic [6:0]        o_address_counter,
    input logic              o_cgram_selected,
    input logic signed [7:0] o_display_shift
);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_read_data))
        else $error("result changed while stalled");

    // Writes return no read data.
    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_read_valid |-> o_read_data == 8'h00)
        else $error("write returned read data");

    // The display shift stays within its wrapped window.
    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_display_shift >= -8'sd80 && o_display_shift <= 8'sd79)
        else $error("display shift out of range");

    // Character RAM addresses never exceed its depth.
    a_cg_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_cgram_selected |-> o_address_counter < 7'd64)
        else $error("character RAM address out of range");

    // One request is worked on at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request accepted while busy");

endmodule

bind char_lcd_controller_bus clcd_checker u_clcd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_ready        (o_in_ready),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_read_data       (o_read_data),
    .o_read_valid      (o_read_valid),
    .o_address_counter (o_address_counter),
    .o_cgram_selected  (o_cgram_selected),
    .o_display_shift   (o_display_shift)
);
